/* hw/rtl/sfst_pkg.sv */
package sfst_pkg;

    localparam int DEPTH_DEF  = 64;
    localparam int CAP_W      = 7;
    localparam int FIELD_W    = 32;
    localparam int ENTRY_W    = 2 * FIELD_W;
    localparam int USED_W     = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TAKE   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // result of the shared entry comparator
    typedef struct packed {
        logic ge;
        logic eq;
    } cmp_res_t;

endpackage

/* hw/rtl/sorted_free_segment_table_top.sv */
// Operation: op code 3 gives its result without touching the table. Others scan the
//   entries in order, one RAM read and compare each (p entries compared by the scan),
//   then resolve; a successful remove or take then moves s entries one place down, and
//   an insert moves s entries one place up and then writes the new entry.
// Flow: one item at a time; s_ready is low until the result is registered. Each compare is one RAM read.
// Reset (aresetn low, synchronous): count 0, capacity 64, no result; RAM not cleared.
module sorted_free_segment_table_top
    import sfst_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CAP_W-1:0]   cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [FIELD_W-1:0] s_seg_size,
    input  logic [FIELD_W-1:0] s_seg_offset,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [FIELD_W-1:0] m_fit_size,
    output logic [FIELD_W-1:0] m_fit_offset,
    output logic [USED_W-1:0]  m_entries_in_use
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN_RD  = 8'b0000_0010,
        S_SCAN_CMP = 8'b0000_0100,
        S_RESOLVE  = 8'b0000_1000,
        S_SHIFT_RD = 8'b0001_0000,
        S_SHIFT_WR = 8'b0010_0000,
        S_INSERT   = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t              state_reg,  state_next;
    op_t                 op_reg,     op_next;
    logic [ENTRY_W-1:0]  key_reg,    key_next;
    logic [CW-1:0]       idx_reg,    idx_next;
    logic [CW-1:0]       ptr_reg,    ptr_next;
    logic [CW-1:0]       count_reg,  count_next;
    logic                up_reg,     up_next;
    logic                hit_reg,    hit_next;
    logic                eq_reg,     eq_next;
    logic [ENTRY_W-1:0]  entry_reg,  entry_next;
    status_t             status_reg, status_next;
    logic [ENTRY_W-1:0]  found_reg,  found_next;
    logic [CAP_W-1:0]    cap_reg;

    logic                m_valid_reg, m_valid_next;
    logic [1:0]          m_status_reg, m_status_next;
    logic [ENTRY_W-1:0]  m_found_reg,  m_found_next;
    logic [USED_W-1:0]   m_used_reg,   m_used_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    cmp_res_t            cmp_res;

    logic [CW-1:0]       ptr_dec;
    logic [CW-1:0]       ptr_inc;
    logic [LW-1:0]       cap_ext;
    logic [LW-1:0]       depth_ext;
    logic [LW-1:0]       limit;
    logic                table_full;

    sfst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sfst_cmp u_cmp (
        .entry (ram_rdata),
        .key   (key_reg),
        .res   (cmp_res)
    );

    assign ptr_dec    = ptr_reg - 1'b1;
    assign ptr_inc    = ptr_reg + 1'b1;
    assign cap_ext    = LW'(cap_reg);
    assign depth_ext  = LW'(DEPTH);
    assign limit      = (cap_ext < depth_ext) ? cap_ext : depth_ext;
    assign table_full = (LW'(count_reg) >= limit);

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);

    always_comb begin
        unique case (state_reg)
            S_SCAN_RD:  ram_raddr = idx_reg[AW-1:0];
            S_SHIFT_RD: ram_raddr = up_reg ? ptr_dec[AW-1:0] : ptr_inc[AW-1:0];
            default:    ram_raddr = idx_reg[AW-1:0];
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg[AW-1:0];
        ram_wdata = ram_rdata;
        if (state_reg == S_SHIFT_WR) begin
            ram_we = 1'b1;
        end else if (state_reg == S_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = idx_reg[AW-1:0];
            ram_wdata = key_reg;
        end
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        idx_next      = idx_reg;
        ptr_next      = ptr_reg;
        count_next    = count_reg;
        up_next       = up_reg;
        hit_next      = hit_reg;
        eq_next       = eq_reg;
        entry_next    = entry_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_used_next   = m_used_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = op_t'(s_op);
                    key_next    = {s_seg_size,
                                   (op_t'(s_op) == OP_TAKE) ? {FIELD_W{1'b0}} : s_seg_offset};
                    idx_next    = '0;
                    hit_next    = 1'b0;
                    eq_next     = 1'b0;
                    found_next  = '0;
                    status_next = ST_NOT_FOUND;
                    state_next  = (op_t'(s_op) == OP_NONE) ? S_DONE : S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                // ran off the end: insertion point is the tail
                state_next = (idx_reg == count_reg) ? S_RESOLVE : S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (cmp_res.ge) begin
                    hit_next   = 1'b1;
                    eq_next    = cmp_res.eq;
                    entry_next = ram_rdata;
                    state_next = S_RESOLVE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_RESOLVE: begin
                ptr_next   = idx_reg;
                up_next    = 1'b0;
                state_next = S_DONE;
                unique case (op_reg)
                    OP_ADD: begin
                        if (hit_reg && eq_reg) begin
                            status_next = ST_DUPLICATE;
                        end else if (table_full) begin
                            status_next = ST_FULL;
                        end else begin
                            up_next    = 1'b1;
                            ptr_next   = count_reg;
                            state_next = S_SHIFT_RD;
                        end
                    end
                    OP_REMOVE: begin
                        if (hit_reg && eq_reg) begin
                            state_next = S_SHIFT_RD;
                        end
                    end
                    OP_TAKE: begin
                        if (hit_reg) begin
                            found_next = entry_reg;
                            state_next = S_SHIFT_RD;
                        end
                    end
                    OP_NONE: begin
                        status_next = ST_NOT_FOUND;
                    end
                endcase
            end
            S_SHIFT_RD: begin
                if (up_reg) begin
                    state_next = (ptr_reg == idx_reg) ? S_INSERT : S_SHIFT_WR;
                end else if (ptr_inc == count_reg) begin
                    count_next  = count_reg - 1'b1;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                ptr_next   = up_reg ? ptr_dec : ptr_inc;
                state_next = S_SHIFT_RD;
            end
            S_INSERT: begin
                count_next  = count_reg + 1'b1;
                status_next = ST_OK;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_found_next  = found_reg;
                    m_used_next   = USED_W'(count_reg);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        ptr_reg      <= ptr_next;
        up_reg       <= up_next;
        hit_reg      <= hit_next;
        eq_reg       <= eq_next;
        entry_reg    <= entry_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_used_reg   <= m_used_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_fit_size       = m_found_reg[ENTRY_W-1:FIELD_W];
    assign m_fit_offset     = m_found_reg[FIELD_W-1:0];
    assign m_entries_in_use = m_used_reg;

endmodule

/* hw/rtl/sfst_ram.sv */
module sfst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/sfst_cmp.sv */
module sfst_cmp
    import sfst_pkg::*;
(
    input  logic [ENTRY_W-1:0] entry,
    input  logic [ENTRY_W-1:0] key,
    output cmp_res_t           res
);

    // {size, offset} as one word compares in table order
    assign res.ge = (entry >= key);
    assign res.eq = (entry == key);

endmodule

/* hw/rtl/sfst_chk.sv */
module sfst_chk
    import sfst_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_status,
    input logic [FIELD_W-1:0] m_fit_size,
    input logic [FIELD_W-1:0] m_fit_offset,
    input logic [USED_W-1:0]  m_entries_in_use
);

    // nothing pending straight out of reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat pending after reset");

    // only a successful take carries a segment
    a_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_fit_size == '0 && m_fit_offset == '0))
        else $error("segment reported on a failed operation");

    // one item at a time: busy the cycle after an input beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while previous item still in work");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)
                                   && $stable(m_entries_in_use)))
        else $error("stalled result beat changed");

endmodule

bind sorted_free_segment_table_top sfst_chk u_sfst_chk (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_fit_size       (m_fit_size),
    .m_fit_offset     (m_fit_offset),
    .m_entries_in_use (m_entries_in_use)
);
